FILE: rtl/core/cst_pkg.sv
// cst_pkg: shared widths, operation codes and fixed-point constants for the
// categorical sampler table. No dependencies.
`default_nettype none
package cst_pkg;

  localparam int FUNC_W     = 2;
  localparam int IDX_OUT_W  = 4;
  localparam int PROB_W     = 17;
  localparam int DRAW_W     = 16;
  localparam int CFG_W      = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  // fixed point, 65536 is 1.0
  localparam logic [PROB_W-1:0] ONE_FIX = 17'h10000;

  // fraction bits produced by the divider after its integer bit
  localparam int DIV_STEPS = 16;
  localparam int DSTEP_W   = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE  = 2'd0,
    FN_SAMPLE = 2'd1,
    FN_ARGMAX = 2'd2,
    FN_READ   = 2'd3
  } func_t;

endpackage
`default_nettype wire

FILE: rtl/core/categorical_sampler_table_unit.sv
// categorical_sampler_table_unit: probability table with write/renormalize,
// inverse-cdf sample, argmax and read, built around one shared bit-serial divider.
// Depends on cst_pkg.
//
// channel   dir  signals                               contents
// in_       in   in_tvalid/in_tready/in_tdata/in_tuser  one operation request
// out_      out  out_tvalid/out_tready/out_tdata/...    one result per request
// cfg_      in   cfg_wr_en/cfg_wr_data                  active_count register
//
// n = active count. read looks up one entry; sample and argmax walk the entries in order;
// write: a sum pass over the n entries, then a scale pass (one table read, 16
// divider steps, one write-back per entry). A count write keeps the unit
// busy while the divider forms the uniform value.
// rst_n (synchronous) clears the control state and restores the uniform table
// for count min(16, ENTRIES) without a clearing pass, through per-entry valid bits.
// A finished result waits in the output register; a new request is taken meanwhile.
`default_nettype none
module categorical_sampler_table_unit #(
  parameter int ENTRIES = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [3:0] entry_index, [20:4] new_value, [36:21] uniform_draw, [39:37] zero
  input  wire logic [cst_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] func
  input  wire logic [cst_pkg::FUNC_W-1:0]       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [3:0] chosen_index, [20:4] probability_out, [23:21] zero
  output logic [cst_pkg::OUT_DATA_W-1:0]        out_tdata,
  // [0] error_flag
  output logic                                  out_tuser,
  input  wire logic                             cfg_wr_en,
  input  wire logic [cst_pkg::CFG_W-1:0]        cfg_wr_data
);
  import cst_pkg::*;

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int SUM_W   = PROB_W + CNT_W;
  localparam int CNT_RST = (ENTRIES < 16) ? ENTRIES : 16;
  localparam int UNI_RST = 65536 / CNT_RST;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_ACC, S_DIV, S_WB, S_OUT
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [PROB_W-1:0]     uni_r, uni_nxt;
  logic [ENTRIES-1:0]    vld_r, vld_nxt;
  logic [FUNC_W-1:0]     func_r, func_nxt;
  logic [IDX_OUT_W-1:0]  idx_r, idx_nxt;
  logic [PROB_W-1:0]     val_r, val_nxt;
  logic [DRAW_W-1:0]     draw_r, draw_nxt;
  logic [CNT_W-1:0]      i_r, i_nxt;
  logic                  pass_r, pass_nxt;
  logic [SUM_W-1:0]      acc_r, acc_nxt;
  logic [PROB_W-1:0]     best_r, best_nxt;
  logic [CNT_W-1:0]      bidx_r, bidx_nxt;
  logic [SUM_W-1:0]      rem_r, rem_nxt;
  logic [SUM_W-1:0]      den_r, den_nxt;
  logic [PROB_W-1:0]     quo_r, quo_nxt;
  logic [DSTEP_W-1:0]    dstep_r, dstep_nxt;
  logic                  duni_r, duni_nxt;
  logic [IDX_OUT_W-1:0]  res_idx_r, res_idx_nxt;
  logic [PROB_W-1:0]     res_prob_r, res_prob_nxt;
  logic                  res_err_r, res_err_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [IDX_OUT_W-1:0]  out_idx_r, out_idx_nxt;
  logic [PROB_W-1:0]     out_prob_r, out_prob_nxt;
  logic                  out_err_r, out_err_nxt;

  // table memory
  logic [PROB_W-1:0]     mem [ENTRIES];
  logic [PROB_W-1:0]     rd_data_r;
  logic                  vld_rd_r;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [PROB_W-1:0]     mem_wdata;

  // request fields
  logic [IDX_OUT_W-1:0]  in_idx;
  logic [PROB_W-1:0]     in_val;
  logic [DRAW_W-1:0]     in_draw;
  logic [PROB_W-1:0]     val_sat;
  logic [31:0]           in_idx_ext;
  logic                  idx_ok;
  logic [31:0]           cfg_ext;
  logic [31:0]           cnt_cl;
  logic                  cfg_go;
  logic                  in_acc;

  // walker helpers
  logic [PROB_W-1:0]     eff;
  logic                  last;
  logic [31:0]           i_ext;
  logic [31:0]           bidx_ext;
  logic [SUM_W-1:0]      acc_sum;

  // shared divider
  logic [PROB_W-1:0]     div_num;
  logic [SUM_W-1:0]      div_den;
  logic                  div_q0;
  logic [SUM_W-1:0]      div_rem0;
  logic [SUM_W:0]        div_r2;
  logic                  div_ge;
  logic [SUM_W:0]        div_sub;
  logic                  div_end;

  assign in_idx     = in_tdata[3:0];
  assign in_val     = in_tdata[20:4];
  assign in_draw    = in_tdata[36:21];
  assign val_sat    = (in_val > ONE_FIX) ? ONE_FIX : in_val;
  assign in_idx_ext = 32'(in_idx);
  assign idx_ok     = (in_idx_ext < 32'(cnt_r));
  assign cfg_ext    = 32'(cfg_wr_data);
  assign cnt_cl     = (cfg_ext == 32'd0) ? 32'd1 :
                      (cfg_ext > 32'(ENTRIES)) ? 32'(ENTRIES) : cfg_ext;
  // count writes land while idle or while a previous count write is dividing
  assign cfg_go     = cfg_wr_en && ((state_r == S_IDLE) || ((state_r == S_DIV) && duni_r));

  assign in_tready  = (state_r == S_IDLE) && !cfg_wr_en;
  assign in_acc     = in_tvalid && in_tready;

  assign eff        = vld_rd_r ? rd_data_r : uni_r;
  assign last       = ((i_r + CNT_W'(1)) == cnt_r);
  assign i_ext      = 32'(i_r);
  assign bidx_ext   = 32'(bidx_r);
  assign acc_sum    = acc_r + SUM_W'(eff);

  // divider start: integer bit of num*65536/den, valid since num <= den
  assign div_num    = cfg_go ? PROB_W'(1) : eff;
  assign div_den    = cfg_go ? SUM_W'(cnt_cl[CNT_W-1:0]) : acc_r;
  assign div_q0     = (SUM_W'(div_num) >= div_den);
  assign div_rem0   = SUM_W'(div_num) - (div_q0 ? div_den : '0);

  // divider step: one quotient bit per cycle
  assign div_r2     = {rem_r, 1'b0};
  assign div_ge     = (div_r2 >= {1'b0, den_r});
  assign div_sub    = div_r2 - {1'b0, den_r};
  assign div_end    = (dstep_r == DSTEP_W'(DIV_STEPS - 1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    uni_nxt       = uni_r;
    vld_nxt       = vld_r;
    func_nxt      = func_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    draw_nxt      = draw_r;
    i_nxt         = i_r;
    pass_nxt      = pass_r;
    acc_nxt       = acc_r;
    best_nxt      = best_r;
    bidx_nxt      = bidx_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    dstep_nxt     = dstep_r;
    duni_nxt      = duni_r;
    res_idx_nxt   = res_idx_r;
    res_prob_nxt  = res_prob_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_prob_nxt  = out_prob_r;
    out_err_nxt   = out_err_r;
    mem_we        = 1'b0;
    mem_waddr     = i_r[IDX_W-1:0];
    mem_wdata     = quo_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt     = in_tuser;
          idx_nxt      = in_idx;
          val_nxt      = val_sat;
          draw_nxt     = in_draw;
          res_idx_nxt  = in_idx;
          res_prob_nxt = '0;
          res_err_nxt  = 1'b0;
          pass_nxt     = 1'b0;
          acc_nxt      = '0;
          i_nxt        = '0;
          state_nxt    = S_RD;
          case (func_t'(in_tuser))
            FN_WRITE: begin
              if (!idx_ok) begin
                res_err_nxt = 1'b1;
                state_nxt   = S_OUT;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = in_idx_ext[IDX_W-1:0];
                mem_wdata = val_sat;
                vld_nxt[in_idx_ext[IDX_W-1:0]] = 1'b1;
              end
            end
            FN_READ: begin
              if (!idx_ok) begin
                res_err_nxt = 1'b1;
                state_nxt   = S_OUT;
              end else begin
                i_nxt = in_idx_ext[CNT_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RD: begin
        state_nxt = S_ACC;
      end

      S_ACC: begin
        state_nxt = S_RD;
        i_nxt     = i_r + CNT_W'(1);
        case (func_t'(func_r))
          FN_READ: begin
            res_prob_nxt = eff;
            state_nxt    = S_OUT;
          end
          FN_ARGMAX: begin
            if (i_r == '0 || eff > best_r) begin
              best_nxt = eff;
              bidx_nxt = i_r;
            end
            if (last) begin
              if (i_r == '0 || eff > best_r) begin
                res_idx_nxt  = i_ext[IDX_OUT_W-1:0];
                res_prob_nxt = eff;
              end else begin
                res_idx_nxt  = bidx_ext[IDX_OUT_W-1:0];
                res_prob_nxt = best_r;
              end
              state_nxt = S_OUT;
            end
          end
          FN_SAMPLE: begin
            acc_nxt = acc_sum;
            // first hit, or the last active entry if none qualifies
            if (acc_sum >= SUM_W'(draw_r) || last) begin
              res_idx_nxt  = i_ext[IDX_OUT_W-1:0];
              res_prob_nxt = eff;
              state_nxt    = S_OUT;
            end
          end
          default: begin
            if (!pass_r) begin
              acc_nxt = acc_sum;
              if (last) begin
                i_nxt = '0;
                if (acc_sum == '0) begin
                  res_err_nxt  = 1'b1;
                  res_prob_nxt = val_r;
                  state_nxt    = S_OUT;
                end else begin
                  pass_nxt = 1'b1;
                end
              end
            end else begin
              i_nxt     = i_r;
              den_nxt   = div_den;
              rem_nxt   = div_rem0;
              quo_nxt   = PROB_W'(div_q0);
              dstep_nxt = '0;
              duni_nxt  = 1'b0;
              state_nxt = S_DIV;
            end
          end
        endcase
      end

      S_DIV: begin
        rem_nxt   = div_ge ? div_sub[SUM_W-1:0] : div_r2[SUM_W-1:0];
        quo_nxt   = {quo_r[PROB_W-2:0], div_ge};
        dstep_nxt = dstep_r + DSTEP_W'(1);
        if (div_end) begin
          if (duni_r) begin
            uni_nxt   = {quo_r[PROB_W-2:0], div_ge};
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_WB;
          end
        end
      end

      S_WB: begin
        mem_we = 1'b1;
        vld_nxt[i_r[IDX_W-1:0]] = 1'b1;
        if (i_ext == 32'(idx_r)) begin
          res_prob_nxt = quo_r;
        end
        if (last) begin
          state_nxt = S_OUT;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_RD;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_prob_nxt  = res_prob_r;
          out_err_nxt   = res_err_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_go) begin
      // new count: reload uniform table, divider forms 65536/count
      cnt_nxt   = cnt_cl[CNT_W-1:0];
      vld_nxt   = '0;
      den_nxt   = div_den;
      rem_nxt   = div_rem0;
      quo_nxt   = PROB_W'(div_q0);
      dstep_nxt = '0;
      duni_nxt  = 1'b1;
      state_nxt = S_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CNT_W'(CNT_RST);
      uni_r       <= PROB_W'(UNI_RST);
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      uni_r       <= uni_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r     <= func_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    draw_r     <= draw_nxt;
    i_r        <= i_nxt;
    pass_r     <= pass_nxt;
    acc_r      <= acc_nxt;
    best_r     <= best_nxt;
    bidx_r     <= bidx_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    quo_r      <= quo_nxt;
    dstep_r    <= dstep_nxt;
    duni_r     <= duni_nxt;
    res_idx_r  <= res_idx_nxt;
    res_prob_r <= res_prob_nxt;
    res_err_r  <= res_err_nxt;
    out_idx_r  <= out_idx_nxt;
    out_prob_r <= out_prob_nxt;
    out_err_r  <= out_err_nxt;
  end

  // one write port, one registered read port at the walker address
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[i_r[IDX_W-1:0]];
    vld_rd_r  <= vld_r[i_r[IDX_W-1:0]];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_prob_r, out_idx_r};
  assign out_tuser  = out_err_r;

endmodule
`default_nettype wire

FILE: tb/tb_categorical_sampler_table_unit.sv
`timescale 1ns / 100ps
// tb_categorical_sampler_table_unit: self-checking bench for the probability table unit,
// with a table tracker that predicts every result and random idling on both streams.
// Depends on cst_pkg and categorical_sampler_table_unit.

import cst_pkg::*;

typedef struct packed {
  logic [IDX_OUT_W-1:0] chosen;
  logic [PROB_W-1:0]    prob;
  logic                 err;
} table_result_t;

typedef enum int {
  IDLE_NONE,
  IDLE_SENDER,
  IDLE_RECEIVER,
  IDLE_BOTH
} idle_mode_t;

// mirrors the probability table and holds the results still owed by the unit
class prob_table_tracker;
  logic [PROB_W-1:0] entry_value [16];
  int unsigned       live_count;
  table_result_t     owed_results [$];
  int unsigned       failures;
  int unsigned       checked;
  int unsigned       per_func [4];
  int unsigned       error_results;

  function new();
    failures = 0;
    checked = 0;
    error_results = 0;
    foreach (per_func[k]) per_func[k] = 0;
    reload(5'd16);
  endfunction

  function void reload(logic [CFG_W-1:0] count);
    int unsigned n;
    n = count;
    if (n < 1) n = 1;
    if (n > 16) n = 16;
    live_count = n;
    foreach (entry_value[k]) entry_value[k] = (k < n) ? PROB_W'(ONE_FIX / n) : '0;
  endfunction

  function int unsigned pending();
    return owed_results.size();
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // apply one accepted request to the table and queue its result
  function void note_request(func_t op, logic [3:0] idx, logic [PROB_W-1:0] val,
                             logic [DRAW_W-1:0] draw);
    table_result_t     r;
    longint unsigned   total;
    longint unsigned   run;
    logic [PROB_W-1:0] best;
    int unsigned       pick;
    bit                found;
    int unsigned       i;
    r.chosen = idx;
    r.prob = '0;
    r.err = 1'b0;
    per_func[int'(op)]++;
    case (op)
      FN_WRITE, FN_READ: begin
        if (idx >= live_count) begin
          r.err = 1'b1;
        end else if (op == FN_READ) begin
          r.prob = entry_value[idx];
        end else begin
          entry_value[idx] = (val > ONE_FIX) ? ONE_FIX : val;
          total = 0;
          for (i = 0; i < live_count; i++) total += entry_value[i];
          if (total == 0) begin
            // all active entries zero, table kept as written
            r.err = 1'b1;
          end else begin
            for (i = 0; i < live_count; i++)
              entry_value[i] = PROB_W'((longint'(entry_value[i]) * ONE_FIX) / total);
          end
          r.prob = entry_value[idx];
        end
      end
      FN_SAMPLE: begin
        pick = live_count - 1;
        run = 0;
        found = 1'b0;
        for (i = 0; i < live_count && !found; i++) begin
          run += entry_value[i];
          if (run >= draw) begin
            pick = i;
            found = 1'b1;
          end
        end
        r.chosen = IDX_OUT_W'(pick);
        r.prob = entry_value[pick];
      end
      default: begin
        best = entry_value[0];
        pick = 0;
        for (i = 1; i < live_count; i++) begin
          if (entry_value[i] > best) begin
            best = entry_value[i];
            pick = i;
          end
        end
        r.chosen = IDX_OUT_W'(pick);
        r.prob = best;
      end
    endcase
    if (r.err) error_results++;
    owed_results.push_back(r);
  endfunction

  function void check_result(logic [OUT_DATA_W-1:0] data, logic flag);
    table_result_t want;
    logic [IDX_OUT_W-1:0] got_idx;
    logic [PROB_W-1:0]    got_prob;
    got_idx = data[IDX_OUT_W-1:0];
    got_prob = data[IDX_OUT_W +: PROB_W];
    if (owed_results.size() == 0) begin
      note_failure($sformatf("result with no request owed: idx=%0d prob=%0d err=%0b",
                             got_idx, got_prob, flag));
      return;
    end
    want = owed_results.pop_front();
    checked++;
    if (got_idx !== want.chosen || got_prob !== want.prob || flag !== want.err)
      note_failure($sformatf("expected idx=%0d prob=%0d err=%0b, got idx=%0d prob=%0d err=%0b",
                             want.chosen, want.prob, want.err, got_idx, got_prob, flag));
  endfunction
endclass

module tb_categorical_sampler_table_unit;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 73;
  localparam int PHASES      = 14;
  localparam int QUIET_TAIL  = 350;
  localparam logic [CFG_W-1:0] COUNT_PLAN [12] = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd0, 5'd3,
                                                   5'd7, 5'd5, 5'd16, 5'd4, 5'd9, 5'd2};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [FUNC_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  prob_table_tracker sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned count_writes = 0;

  categorical_sampler_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check, then choose ready for the next cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (hold_toggle != hold_seen) begin
        hold_seen <= hold_toggle;
        hold_left <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("** categorical_sampler_table_unit: FAILED **");
        $finish;
      end
    end
  end

  task automatic set_idling(idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 73 : (mode == IDLE_BOTH) ? 22 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 73 : (mode == IDLE_BOTH) ? 22 : 0;
  endtask

  task automatic send_request(func_t op, logic [3:0] idx, logic [PROB_W-1:0] val,
                              logic [DRAW_W-1:0] draw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b000, draw, val, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, idx, val, draw);
  endtask

  task automatic send_random_request();
    func_t             op;
    logic [3:0]        idx;
    logic [PROB_W-1:0] val;
    logic [DRAW_W-1:0] draw;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 35) op = FN_WRITE;
    else if (pick < 60) op = FN_SAMPLE;
    else if (pick < 75) op = FN_ARGMAX;
    else op = FN_READ;
    // mostly in range, some indexes beyond the active count
    if ($urandom_range(99) < 30) idx = 4'($urandom_range(15));
    else idx = 4'($urandom_range(sb.live_count - 1));
    case ($urandom_range(9))
      0, 1: val = '0;
      2: val = ONE_FIX;
      3: val = PROB_W'($urandom_range(131071, 65537));
      4: val = PROB_W'($urandom_range(255));
      default: val = PROB_W'($urandom_range(65535));
    endcase
    case ($urandom_range(9))
      0: draw = '0;
      1: draw = '1;
      default: draw = DRAW_W'($urandom);
    endcase
    send_request(op, idx, val, draw);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_count(logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.reload(value);
    count_writes++;
  endtask

  initial begin
    int unsigned ph;
    int unsigned n;
    logic [CFG_W-1:0] next_count;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // uniform table left by reset
    send_request(FN_READ, 4'd0, '0, '0);
    send_request(FN_READ, 4'd15, '0, '0);
    send_request(FN_ARGMAX, 4'd0, '0, '0);
    send_request(FN_SAMPLE, 4'd0, '0, 16'h0000);
    send_request(FN_SAMPLE, 4'd0, '0, 16'hffff);
    send_request(FN_SAMPLE, 4'd0, '0, 16'h8000);
    send_request(FN_WRITE, 4'd15, 17'h1ffff, '0);   // saturates to 1.0
    send_request(FN_ARGMAX, 4'd0, '0, '0);
    send_request(FN_WRITE, 4'd3, '0, '0);
    drain();
    // seven entries sum below the largest draw, so the last index is returned
    write_count(5'd7);
    send_request(FN_SAMPLE, 4'd0, '0, 16'hffff);
    send_request(FN_READ, 4'd7, '0, '0);
    send_request(FN_WRITE, 4'd12, 17'd100, '0);
    send_request(FN_READ, 4'd6, '0, '0);
    drain();
    // count of zero acts as one
    write_count(5'd0);
    send_request(FN_WRITE, 4'd0, '0, '0);
    send_request(FN_READ, 4'd0, '0, '0);
    send_request(FN_SAMPLE, 4'd0, '0, 16'h0000);
    send_request(FN_SAMPLE, 4'd0, '0, 16'h0001);
    send_request(FN_ARGMAX, 4'd0, '0, '0);
    send_request(FN_WRITE, 4'd0, 17'd17, '0);
    drain();
    write_count(5'd2);
    send_request(FN_WRITE, 4'd0, '0, '0);
    send_request(FN_WRITE, 4'd1, '0, '0);
    drain();
    write_count(5'd31);
    send_request(FN_WRITE, 4'd15, 17'd65535, '0);
    send_request(FN_READ, 4'd15, '0, '0);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      next_count = (ph < 12) ? COUNT_PLAN[ph] : CFG_W'($urandom_range(31));
      write_count(next_count);
      set_idling(idle_mode_t'(ph % 4));
      // long receiver hold-off while requests keep coming
      if (ph == 8) hold_toggle <= ~hold_toggle;
      for (n = 0; n < PHASE_ITEMS; n++) send_random_request();
      drain();
    end

    set_idling(IDLE_NONE);
    repeat (QUIET_TAIL) @(posedge clk);
    sb.failures += sb.pending();
    $display("checked %0d results: %0d writes, %0d samples, %0d argmax, %0d reads",
             sb.checked, sb.per_func[int'(FN_WRITE)], sb.per_func[int'(FN_SAMPLE)],
             sb.per_func[int'(FN_ARGMAX)], sb.per_func[int'(FN_READ)]);
    $display("%0d results flagged an error, %0d count settings, %0d failures",
             sb.error_results, count_writes, sb.failures);
    if (sb.failures == 0) begin
      $display("** categorical_sampler_table_unit: PASSED **");
    end else begin
      $display("** categorical_sampler_table_unit: FAILED **");
    end
    $finish;
  end

endmodule
